### design/sm4_block_encrypt_unit_assert.svh
// Assertion macros shared by the SM4 encrypt unit modules.
`ifndef SM4_BLOCK_ENCRYPT_UNIT_ASSERT_SVH
`define SM4_BLOCK_ENCRYPT_UNIT_ASSERT_SVH
// Consequent must hold in the same cycle as the antecedent.
`define SM4_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("SM4 same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define SM4_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("SM4 next-cycle check failed");
`endif

### design/sm4_pkg.sv
// Shared types, constants and round functions of the SM4 encrypt unit.
`default_nettype none

package sm4_pkg;

    // Round count and round counter width.
    localparam int unsigned ROUNDS    = 32;
    localparam int unsigned RND_IDX_W = $clog2(ROUNDS);

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    typedef logic [31:0] word_t;
    // Four state words; index 0 is the first word of the block.
    typedef word_t [3:0] blk_t;
    typedef word_t [ROUNDS-1:0] rk_arr_t;

    // System parameter FK.
    localparam word_t FK0 = 32'ha3b1bac6;
    localparam word_t FK1 = 32'h56aa3350;
    localparam word_t FK2 = 32'h677d9197;
    localparam word_t FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // Left rotation by a constant amount between 1 and 31.
    function automatic word_t rotl(input word_t x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Byte-wise S-box substitution.
    function automatic word_t sub_word(input word_t x);
        return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    // Key schedule transform: substitution, then L' with rotations 13 and 23.
    function automatic word_t t_key(input word_t x);
        word_t b;
        b = sub_word(x);
        return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // Data round transform: substitution, then L with rotations 2, 10, 18, 24.
    function automatic word_t t_data(input word_t x);
        word_t b;
        b = sub_word(x);
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    // CK constant of a round: byte j is ((4*i + j) * 7) mod 256.
    function automatic word_t ck_word(input logic [RND_IDX_W-1:0] i);
        word_t      w;
        logic [7:0] idx;
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            idx = 8'({i, 2'b00}) + 8'(j);
            w   = {w[23:0], idx * 8'd7};
        end
        return w;
    endfunction

endpackage

`default_nettype wire

### design/sm4_key_sched.sv
// Key registers and iterative SM4 round key expansion, one round key per cycle.
`default_nettype none

module sm4_key_sched (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    input  wire logic [sm4_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [63:0]                     cfg_data,
    output sm4_pkg::rk_arr_t                     rk,
    output logic                                 busy
);

    logic [63:0]                     key_high_reg;
    logic [63:0]                     key_low_reg;
    logic                            load_pend_reg;
    logic                            run_reg;
    logic [sm4_pkg::RND_IDX_W-1:0]   cnt_reg;
    sm4_pkg::blk_t                   k_reg;
    sm4_pkg::rk_arr_t                rk_reg;
    sm4_pkg::word_t                  nw;

    localparam logic [sm4_pkg::RND_IDX_W-1:0] LAST_RND = sm4_pkg::RND_IDX_W'(sm4_pkg::ROUNDS - 1);

    // Key registers, restart request and round counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            load_pend_reg <= 1'b1;
            run_reg       <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    sm4_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                    sm4_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    default:               key_low_reg  <= key_low_reg;
                endcase
            end
            load_pend_reg <= cfg_valid;
            if (load_pend_reg)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_RND)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // Next key word of the expansion.
    assign nw = k_reg[0] ^ sm4_pkg::t_key(k_reg[1] ^ k_reg[2] ^ k_reg[3]
                                          ^ sm4_pkg::ck_word(cnt_reg));

    // Key word window and round key store.
    always_ff @(posedge clk)
    begin
        if (load_pend_reg)
        begin
            k_reg[0] <= key_high_reg[63:32] ^ sm4_pkg::FK0;
            k_reg[1] <= key_high_reg[31:0]  ^ sm4_pkg::FK1;
            k_reg[2] <= key_low_reg[63:32]  ^ sm4_pkg::FK2;
            k_reg[3] <= key_low_reg[31:0]   ^ sm4_pkg::FK3;
        end
        else if (run_reg)
        begin
            k_reg           <= {nw, k_reg[3], k_reg[2], k_reg[1]};
            rk_reg[cnt_reg] <= nw;
        end
    end

    assign rk   = rk_reg;
    assign busy = cfg_valid || load_pend_reg || run_reg;

    `include "sm4_block_encrypt_unit_assert.svh"

    // The expansion stops after the last round key unless a restart is pending.
    `SM4_ASSERT_NEXT(a_run_stops, run_reg && (cnt_reg == LAST_RND) && !load_pend_reg, !run_reg)
    // A restart always begins the expansion from the first round.
    `SM4_ASSERT_NEXT(a_restart_runs, load_pend_reg, run_reg && (cnt_reg == '0))
    // The unit reports busy for as long as a restart or the expansion is underway.
    `SM4_ASSERT_SAME(a_busy_covers_expansion, load_pend_reg || run_reg, busy)

endmodule

`default_nettype wire

### design/sm4_round_stage.sv
// One registered SM4 data round of the pipeline.
`default_nettype none

module sm4_round_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  sm4_pkg::blk_t         in_words,
    input  sm4_pkg::word_t        rk,
    output logic                  out_valid,
    output sm4_pkg::blk_t         out_words
);

    logic           valid_reg;
    sm4_pkg::blk_t  words_reg;
    sm4_pkg::blk_t  words_next;

    // Round: drop the oldest word and append X0 ^ T(X1 ^ X2 ^ X3 ^ rk).
    always_comb
    begin
        words_next[0] = in_words[1];
        words_next[1] = in_words[2];
        words_next[2] = in_words[3];
        words_next[3] = in_words[0]
                        ^ sm4_pkg::t_data(in_words[1] ^ in_words[2] ^ in_words[3] ^ rk);
    end

    // Valid bit advances with the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // State words.
    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            words_reg <= words_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_words = words_reg;

endmodule

`default_nettype wire

### design/sm4_block_encrypt_unit.sv
// Top level of the pipelined SM4 block encrypt unit.
//
//  Channel   Direction  Signals                                  Content
//  s_axis    in         s_tvalid, s_tready, s_tdata[127:0]       plaintext block
//  m_axis    out        m_tvalid, m_tready, m_tdata[127:0]       ciphertext block
//  cfg       in         cfg_valid, cfg_ready, cfg_index, cfg_data  key registers
//
// One block is taken per cycle while s_tready is high; a block reaches m_axis through
// 32 round stages, the first loaded at the transfer edge, and then the output register.
// After reset and after each key write the round key expansion runs, one round key per
// cycle, and s_tready stays low meanwhile; cfg writes are always taken.
// A two-entry output buffer (output register plus skid register) lets the pipeline keep
// moving until the skid register fills; s_tready depends only on registered state and cfg.
`default_nettype none

module sm4_block_encrypt_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [127:0]                    s_tdata,   // plain_high[63:0], plain_low[127:64]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [127:0]                         m_tdata,   // cipher_high[63:0], cipher_low[127:64]
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sm4_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [63:0]                     cfg_data
);

    sm4_pkg::rk_arr_t          rk;
    logic                      key_busy;
    logic                      pipe_en;
    logic [sm4_pkg::ROUNDS:0]  stage_valid;
    sm4_pkg::blk_t             stage_words [sm4_pkg::ROUNDS+1];
    sm4_pkg::blk_t             last_words;
    logic [127:0]              result;
    logic                      emit;
    logic                      out_valid_reg;
    logic [127:0]              out_data_reg;
    logic                      skid_valid_reg;
    logic [127:0]              skid_data_reg;

    // Round key expansion.
    sm4_key_sched u_key_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rk        (rk),
        .busy      (key_busy)
    );

    assign cfg_ready = 1'b1;

    // The pipeline moves whenever the skid register is free.
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en && !key_busy;

    // Input block split into state words X0..X3.
    assign stage_valid[0]    = s_tvalid && s_tready;
    assign stage_words[0][0] = s_tdata[63:32];
    assign stage_words[0][1] = s_tdata[31:0];
    assign stage_words[0][2] = s_tdata[127:96];
    assign stage_words[0][3] = s_tdata[95:64];

    // One pipeline stage per round.
    for (genvar r = 0; r < sm4_pkg::ROUNDS; r++)
    begin : g_round
        sm4_round_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (stage_valid[r]),
            .in_words  (stage_words[r]),
            .rk        (rk[r]),
            .out_valid (stage_valid[r+1]),
            .out_words (stage_words[r+1])
        );
    end

    // Final words come out in reverse order.
    assign last_words = stage_words[sm4_pkg::ROUNDS];
    assign result     = {last_words[1], last_words[0], last_words[3], last_words[2]};
    assign emit       = pipe_en && stage_valid[sm4_pkg::ROUNDS];

    // Output and skid valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (m_tready)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (emit)
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output and skid data.
    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (emit)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_data_reg <= result;
            end
            else
            begin
                skid_data_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `include "sm4_block_encrypt_unit_assert.svh"

    // The skid register only holds data behind a waiting output register.
    `SM4_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // The skid register fills only when the output was stalled.
    `SM4_ASSERT_SAME(a_skid_fill_on_stall, $rose(skid_valid_reg), $past(out_valid_reg && !m_tready))
    // The output only empties after a transfer.
    `SM4_ASSERT_SAME(a_out_drain_on_transfer, $fell(out_valid_reg), $past(m_tready))

endmodule

`default_nettype wire
